// ===== hw/rtl/emr_pkg.sv =====
// shared types, constants and tables for the euler to rotation matrix core
package emr_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int MAX_STAGES    = 24;
    localparam int NUM_STAGES    = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
    localparam int STAGE_W       = $clog2(MAX_STAGES);

    localparam int ANG_W = 17;
    localparam int XY_W  = 34;
    localparam int Z_W   = 26;
    localparam int TRIG_W = 18;
    localparam int PROD_W = 36;
    localparam int OUT_W  = 16;

    localparam logic signed [XY_W-1:0] GAIN_Q30 = XY_W'(652032874);

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   neg_cos;
    } cordic_t;

    // atan(2^-i) in degrees * 2^16
    function automatic logic signed [Z_W-1:0] atan_lut(input logic [STAGE_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            5'd0:  v = Z_W'(2949120);
            5'd1:  v = Z_W'(1740967);
            5'd2:  v = Z_W'(919879);
            5'd3:  v = Z_W'(466945);
            5'd4:  v = Z_W'(234379);
            5'd5:  v = Z_W'(117304);
            5'd6:  v = Z_W'(58666);
            5'd7:  v = Z_W'(29335);
            5'd8:  v = Z_W'(14668);
            5'd9:  v = Z_W'(7334);
            5'd10: v = Z_W'(3667);
            5'd11: v = Z_W'(1833);
            5'd12: v = Z_W'(917);
            5'd13: v = Z_W'(458);
            5'd14: v = Z_W'(229);
            5'd15: v = Z_W'(115);
            5'd16: v = Z_W'(57);
            5'd17: v = Z_W'(29);
            5'd18: v = Z_W'(14);
            5'd19: v = Z_W'(7);
            5'd20: v = Z_W'(4);
            5'd21: v = Z_W'(2);
            5'd22: v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/emr_angle_prep.sv =====
// angle wrap and quadrant fold into the cordic start vector
module emr_angle_prep import emr_pkg::*; (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [ANG_W-1:0] ang,
    output cordic_t                 prep_out
);

    localparam logic signed [17:0] TURN    = 18'sd46080;
    localparam logic signed [17:0] HALF    = 18'sd23040;
    localparam logic signed [17:0] QUARTER = 18'sd11520;

    logic signed [17:0] a0, a1, a2, a3;
    logic               neg;

    always_comb begin
        a0 = 18'(ang);
        // truncating remainder, keeps the sign of the angle
        if (a0 >= TURN) begin
            a1 = a0 - TURN;
        end else if (a0 <= -TURN) begin
            a1 = a0 + TURN;
        end else begin
            a1 = a0;
        end
        if (a1 > HALF) begin
            a2 = a1 - TURN;
        end else if (a1 < -HALF) begin
            a2 = a1 + TURN;
        end else begin
            a2 = a1;
        end
        neg = 1'b0;
        if (a2 > QUARTER) begin
            a3  = HALF - a2;
            neg = 1'b1;
        end else if (a2 < -QUARTER) begin
            a3  = -HALF - a2;
            neg = 1'b1;
        end else begin
            a3 = a2;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prep_out.x       <= GAIN_Q30;
            prep_out.y       <= '0;
            prep_out.z       <= Z_W'(a3) <<< 9;
            prep_out.neg_cos <= neg;
        end
    end

endmodule

// ===== hw/rtl/emr_cordic_cell.sv =====
// one rotation-mode cordic iteration with its pipeline register
module emr_cordic_cell import emr_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic [STAGE_W-1:0] stage,
    input  cordic_t            cell_in,
    output cordic_t            cell_out
);

    logic signed [XY_W-1:0] xs, ys;
    logic signed [Z_W-1:0]  at;

    assign xs = cell_in.x >>> stage;
    assign ys = cell_in.y >>> stage;
    assign at = atan_lut(stage);

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_out.neg_cos <= cell_in.neg_cos;
            if (cell_in.z >= 0) begin
                cell_out.x <= cell_in.x - ys;
                cell_out.y <= cell_in.y + xs;
                cell_out.z <= cell_in.z - at;
            end else begin
                cell_out.x <= cell_in.x + ys;
                cell_out.y <= cell_in.y - xs;
                cell_out.z <= cell_in.z + at;
            end
        end
    end

endmodule

// ===== hw/rtl/emr_matrix.sv =====
// three-stage product, sum, round and saturate for the nine matrix entries
module emr_matrix import emr_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  cordic_t            p_in,
    input  cordic_t            y_in,
    input  cordic_t            r_in,
    output logic [OUT_W-1:0]   r_out [9]
);

    function automatic logic signed [TRIG_W-1:0] to_q16(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] t;
        t = (v + XY_W'(8192)) >>> 14;
        return t[TRIG_W-1:0];
    endfunction

    function automatic logic signed [TRIG_W-1:0] rnd16(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] t;
        t = (v + PROD_W'(32768)) >>> 16;
        return t[TRIG_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] sat14(input logic signed [PROD_W:0] v);
        logic signed [PROD_W:0] t;
        t = (v + (PROD_W+1)'(131072)) >>> 18;
        if (t > (PROD_W+1)'(16384)) begin
            t = (PROD_W+1)'(16384);
        end else if (t < -(PROD_W+1)'(16384)) begin
            t = -(PROD_W+1)'(16384);
        end
        return t[OUT_W-1:0];
    endfunction

    logic signed [TRIG_W-1:0] sp, cp, sy, cy, sr, cr, sysp, cysp;

    logic signed [PROD_W-1:0] cycr_reg, srcp_reg, sycr_reg, cysr_reg, crcp_reg;
    logic signed [PROD_W-1:0] srsy_reg, sycp_reg, cycp_reg, sysp_reg, cysp_reg;
    logic signed [TRIG_W-1:0] sp1_reg, sr1_reg, cr1_reg, sp2_reg;
    logic signed [PROD_W-1:0] cycr2_reg, srcp2_reg, sycr2_reg, cysr2_reg, crcp2_reg;
    logic signed [PROD_W-1:0] srsy2_reg, sycp2_reg, cycp2_reg;
    logic signed [PROD_W-1:0] qa_reg, qb_reg, qc_reg, qd_reg;
    logic signed [PROD_W:0]   neg_sp;

    always_comb begin
        sp = to_q16(p_in.y);
        cp = p_in.neg_cos ? -to_q16(p_in.x) : to_q16(p_in.x);
        sy = to_q16(y_in.y);
        cy = y_in.neg_cos ? -to_q16(y_in.x) : to_q16(y_in.x);
        sr = to_q16(r_in.y);
        cr = r_in.neg_cos ? -to_q16(r_in.x) : to_q16(r_in.x);
        sysp = rnd16(sysp_reg);
        cysp = rnd16(cysp_reg);
        neg_sp = -((PROD_W+1)'(sp2_reg) <<< 16);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cycr_reg <= PROD_W'(cy) * PROD_W'(cr);
            srcp_reg <= PROD_W'(sr) * PROD_W'(cp);
            sycr_reg <= PROD_W'(sy) * PROD_W'(cr);
            cysr_reg <= PROD_W'(cy) * PROD_W'(sr);
            crcp_reg <= PROD_W'(cr) * PROD_W'(cp);
            srsy_reg <= PROD_W'(sr) * PROD_W'(sy);
            sycp_reg <= PROD_W'(sy) * PROD_W'(cp);
            cycp_reg <= PROD_W'(cy) * PROD_W'(cp);
            sysp_reg <= PROD_W'(sy) * PROD_W'(sp);
            cysp_reg <= PROD_W'(cy) * PROD_W'(sp);
            sp1_reg  <= sp;
            sr1_reg  <= sr;
            cr1_reg  <= cr;

            // triple products from the rounded first pair
            qa_reg    <= PROD_W'(sysp) * PROD_W'(sr1_reg);
            qb_reg    <= PROD_W'(cysp) * PROD_W'(sr1_reg);
            qc_reg    <= PROD_W'(sysp) * PROD_W'(cr1_reg);
            qd_reg    <= PROD_W'(cysp) * PROD_W'(cr1_reg);
            cycr2_reg <= cycr_reg;
            srcp2_reg <= srcp_reg;
            sycr2_reg <= sycr_reg;
            cysr2_reg <= cysr_reg;
            crcp2_reg <= crcp_reg;
            srsy2_reg <= srsy_reg;
            sycp2_reg <= sycp_reg;
            cycp2_reg <= cycp_reg;
            sp2_reg   <= sp1_reg;

            r_out[0] <= sat14((PROD_W+1)'(cycr2_reg) + (PROD_W+1)'(qa_reg));
            r_out[1] <= sat14((PROD_W+1)'(srcp2_reg));
            r_out[2] <= sat14((PROD_W+1)'(qb_reg) - (PROD_W+1)'(sycr2_reg));
            r_out[3] <= sat14((PROD_W+1)'(qc_reg) - (PROD_W+1)'(cysr2_reg));
            r_out[4] <= sat14((PROD_W+1)'(crcp2_reg));
            r_out[5] <= sat14((PROD_W+1)'(srsy2_reg) + (PROD_W+1)'(qd_reg));
            r_out[6] <= sat14((PROD_W+1)'(sycp2_reg));
            r_out[7] <= sat14(neg_sp);
            r_out[8] <= sat14((PROD_W+1)'(cycp2_reg));
        end
    end

endmodule

// ===== hw/rtl/euler_to_rotation_matrix_core.sv =====
// top level: euler angles to rotation matrix, pipelined cordic and multipliers
//
// input channel s_*: one angle triple per item, pitch, yaw and roll in signed
// Q9.7 degrees; any 17-bit value is taken and wrapped modulo 360 degrees.
// output channel m_*: one item per input item, the nine entries of the 3x3
// rotation matrix in signed Q1.14, saturated to plus or minus one.
// the pipeline holds one fold stage, the cordic cells (16 cordic stages) and
// three multiply and round stages.
// throughput is one item per cycle while the receiver takes results: each
// cordic cell and each multiply stage takes a new item whenever the pipeline advances.
// the whole pipeline advances together; when the receiver stalls with a
// result in the output register, every stage holds and s_tready drops until
// the result is taken. items keep their order and none is dropped.
// reset (aresetn low, synchronous) empties the pipeline; items in flight are
// discarded and m_tvalid goes low on the next edge.
module euler_to_rotation_matrix_core import emr_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [55:0]  s_tdata,   // pitch_deg[16:0], yaw_deg[33:17], roll_deg[50:34], zeros
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata    // r00, r01, r02, r10, r11, r12, r20, r21, r22, 16 bits each
);

    localparam int LAT = NUM_STAGES + 4;

    logic [LAT-1:0]   vld_reg;
    logic             en;
    cordic_t          chain [3][NUM_STAGES+1];
    logic [OUT_W-1:0] r_out [9];

    assign m_tvalid = vld_reg[LAT-1];
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_ang
        emr_angle_prep u_prep (
            .aclk     (aclk),
            .en       (en),
            .ang      (s_tdata[k*ANG_W +: ANG_W]),
            .prep_out (chain[k][0])
        );
        for (genvar j = 0; j < NUM_STAGES; j++) begin : g_cell
            emr_cordic_cell u_cell (
                .aclk     (aclk),
                .en       (en),
                .stage    (STAGE_W'(j)),
                .cell_in  (chain[k][j]),
                .cell_out (chain[k][j+1])
            );
        end
    end

    emr_matrix u_matrix (
        .aclk  (aclk),
        .en    (en),
        .p_in  (chain[0][NUM_STAGES]),
        .y_in  (chain[1][NUM_STAGES]),
        .r_in  (chain[2][NUM_STAGES]),
        .r_out (r_out)
    );

    for (genvar n = 0; n < 9; n++) begin : g_out
        assign m_tdata[n*OUT_W +: OUT_W] = r_out[n];
    end

endmodule

// ===== hw/rtl/emr_checker.sv =====
// port-level checks for the euler to rotation matrix core
module emr_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [143:0] m_tdata
);

    logic range_ok;

    always_comb begin
        range_ok = 1'b1;
        for (int n = 0; n < 9; n++) begin
            if ($signed(m_tdata[n*16 +: 16]) > 16'sd16384 ||
                $signed(m_tdata[n*16 +: 16]) < -16'sd16384) begin
                range_ok = 1'b0;
            end
        end
    end

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result shown right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> range_ok)
        else $error("matrix entry beyond saturation limit");

endmodule

bind euler_to_rotation_matrix_core emr_checker u_emr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/euler_to_rotation_matrix_core_chk.sv =====
// checker: watches both channels, predicts each rotation matrix and compares
`timescale 1ns / 100ps

module euler_to_rotation_matrix_core_chk import emr_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [55:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [143:0] m_tdata,
    output int           fail_count,
    output int           pending
);

    localparam longint ATAN_Q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    logic [143:0] matrix_q[$];

    // arithmetic shift right rounding half up
    function automatic longint round_shr(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [15:0] sat_q14(input longint q32);
        longint v;
        v = round_shr(q32, 18);
        if (v > 16384) v = 16384;
        if (v < -16384) v = -16384;
        return v[15:0];
    endfunction

    function automatic void angle_trig(input logic signed [16:0] deg, output longint sn,
                                       output longint cs);
        int a;
        bit flip;
        longint x, y, z, xs, ys;
        a = int'(deg) % 46080;
        flip = 0;
        x = 652032874;
        y = 0;
        if (a > 23040) a -= 46080;
        if (a < -23040) a += 46080;
        if (a > 11520) begin
            a = 23040 - a;
            flip = 1;
        end else if (a < -11520) begin
            a = -23040 - a;
            flip = 1;
        end
        z = longint'(a) * 512;
        for (int i = 0; i < NUM_STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= ATAN_Q16[i];
            end else begin
                x += ys; y -= xs; z += ATAN_Q16[i];
            end
        end
        cs = round_shr(x, 14);
        sn = round_shr(y, 14);
        if (flip) cs = -cs;
    endfunction

    function automatic logic [143:0] rotation_of(input logic [55:0] angles);
        longint sp, cp, sy, cy, sr, cr, sysp, cysp;
        logic [15:0] r [9];
        angle_trig(angles[16:0], sp, cp);
        angle_trig(angles[33:17], sy, cy);
        angle_trig(angles[50:34], sr, cr);
        sysp = round_shr(sy * sp, 16);
        cysp = round_shr(cy * sp, 16);
        r[0] = sat_q14(cy * cr + sysp * sr);
        r[1] = sat_q14(sr * cp);
        r[2] = sat_q14(-(sy * cr) + cysp * sr);
        r[3] = sat_q14(-(cy * sr) + sysp * cr);
        r[4] = sat_q14(cr * cp);
        r[5] = sat_q14(sr * sy + cysp * cr);
        r[6] = sat_q14(sy * cp);
        r[7] = sat_q14(-sp * 65536);
        r[8] = sat_q14(cy * cp);
        return {r[8], r[7], r[6], r[5], r[4], r[3], r[2], r[1], r[0]};
    endfunction

    string entry_name [9] = '{"r00", "r01", "r02", "r10", "r11", "r12", "r20", "r21", "r22"};

    initial fail_count = 0;
    assign pending = matrix_q.size();

    always @(posedge aclk) begin
        logic [143:0] want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                matrix_q.push_back(rotation_of(s_tdata));
            if (m_tvalid && m_tready) begin
                if (matrix_q.size() == 0) begin
                    $error("result item with nothing expected: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = matrix_q.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (want[16*k +: 16] !== m_tdata[16*k +: 16]) begin
                            $error("%s expected %0d actual %0d", entry_name[k],
                                   $signed(want[16*k +: 16]), $signed(m_tdata[16*k +: 16]));
                            fail_count++;
                        end
                end
            end
        end
    end

endmodule

// ===== test/euler_to_rotation_matrix_core_tb.sv =====
// testbench top: clock, reset, angle stimulus with idle and stall phases, verdict
`timescale 1ns / 100ps

module euler_to_rotation_matrix_core_tb;
    import emr_pkg::*;

    localparam int LATENCY = NUM_STAGES + 4;
    localparam int CYCLE_LIMIT = 400000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [55:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [143:0] m_tdata;
    int           fail_count;
    int           pending;
    int           cycle_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    euler_to_rotation_matrix_core u_top (.*);

    euler_to_rotation_matrix_core_chk u_chk (.*);

    initial forever #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** euler_to_rotation_matrix_core: FAILED **");
            $finish;
        end
    end

    always @(posedge aclk)
        m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);

    function automatic logic [16:0] rand_angle();
        case ($urandom_range(9))
            0: return 17'($urandom());
            1: return 17'($signed(17'(46080)) * $urandom_range(0, 2) - 17'(46080));
            2: return 17'(11520 * $urandom_range(0, 8) - 46080);
            default: return 17'(int'($urandom_range(0, 92160)) - 46080);
        endcase
    endfunction

    // holds valid high until the item is taken, with random idle cycles first
    task automatic send_angles(input logic [16:0] p, input logic [16:0] y,
                               input logic [16:0] r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {5'b0, r, y, p};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    logic [16:0] edges [10] = '{17'h0, 17'h1, 17'h1FFFF, 17'd46080, -17'sd46080,
        17'd11520, -17'sd11520, 17'd23040, 17'h0FFFF, 17'h10000};

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        foreach (edges[i])
            send_angles(edges[i], edges[(i + 3) % 10], edges[(i + 7) % 10]);
        send_angles(17'd5760, 17'd5760, 17'd5760);
        send_angles(17'd11519, 17'd11521, -17'sd11521);
        send_angles(17'd34560, -17'sd34560, 17'd0);
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1) ? 47 : (ph == 3) ? 35 : 0;
            recv_stall_pct = (ph == 2) ? 47 : (ph == 3) ? 35 : 0;
            for (int n = 0; n < 485; n++) begin
                if (n % 97 == 96) begin
                    s_tvalid <= 0;
                    while (pending != 0) @(posedge aclk);
                end
                send_angles(rand_angle(), rand_angle(), rand_angle());
            end
        end
        drain();
        if (fail_count == 0)
            $display("** euler_to_rotation_matrix_core: PASSED **");
        else
            $display("** euler_to_rotation_matrix_core: FAILED **");
        $finish;
    end

endmodule

// ===== euler_to_rotation_matrix_core.f =====
hw/rtl/emr_pkg.sv
hw/rtl/emr_angle_prep.sv
hw/rtl/emr_cordic_cell.sv
hw/rtl/emr_matrix.sv
hw/rtl/euler_to_rotation_matrix_core.sv
hw/rtl/emr_checker.sv
test/euler_to_rotation_matrix_core_chk.sv
test/euler_to_rotation_matrix_core_tb.sv
